[sv/lps_pkg.sv]
// shared types and constants for the permutation stepper
`default_nettype none
package lps_pkg;
	localparam int MaxLenDefault = 16;

	localparam logic [1:0] REQ_WRITE   = 2'd0;
	localparam logic [1:0] REQ_ADVANCE = 2'd1;
	localparam logic [1:0] REQ_READ    = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [3:0] elem_index;
		logic [7:0] elem_value;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]  read_value;
		logic [15:0] arrangement_sum;
		logic [63:0] running_total;
		logic [47:0] step_count;
		logic [3:0]  pivot_position;
		logic        wrapped;
	} out_beat_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture request, preset scan pointer
		logic sum_clr;
		logic sum_step;  // accumulate one element into the sum
		logic piv_step;  // one step of pivot search
		logic suc_step;  // one step of successor search
		logic swap;
		logic rev_init;
		logic rev_step;
		logic wr_elem;
		logic acc;       // add sum to total, bump count
		logic clr_tot;
		logic finish;    // build result beat
	} cmd_t;

	typedef struct packed {
		logic sum_done;
		logic piv_done;
		logic piv_found;
		logic suc_done;
		logic rev_done;
	} sts_t;
endpackage
`default_nettype wire

[sv/lps_datapath.sv]
// element store, scan pointers, sum and total registers
`default_nettype none
module lps_datapath #(
	parameter int MAX_LEN = lps_pkg::MaxLenDefault,
	localparam int IW = $clog2(MAX_LEN),
	localparam int LW = $clog2(MAX_LEN + 1)
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire lps_pkg::cmd_t     cmd,
	output lps_pkg::sts_t          sts,
	input  wire lps_pkg::in_beat_t in_beat,
	input  wire [4:0]              seq_length,
	output lps_pkg::out_beat_t     res
);
	logic [7:0]  mem_q [MAX_LEN];
	logic [1:0]  req_q;
	logic [3:0]  idx_q;
	logic [7:0]  val_q;
	logic [LW-1:0] len_q;
	logic [IW-1:0] ptr_q;     // sum pointer / pivot scan i / successor scan j
	logic [IW-1:0] piv_q;
	logic [IW-1:0] lo_q, hi_q;
	logic [15:0] sum_q;
	logic [63:0] tot_q;
	logic [47:0] cnt_q;
	logic [LW-1:0] len_c;
	logic [IW-1:0] last_c;
	logic [7:0]  a_c, b_c;
	// marks that the pivot search found a pivot
	logic sts_w_q;

	always_comb begin
		if (seq_length == 5'd0) len_c = LW'(1);
		else if (32'(seq_length) > MAX_LEN) len_c = LW'(MAX_LEN);
		else len_c = LW'(seq_length);
	end
	assign last_c = IW'(len_q - LW'(1));
	assign a_c = mem_q[ptr_q];
	assign b_c = mem_q[ptr_q - IW'(1)];

	assign sts.sum_done  = (ptr_q == last_c);
	assign sts.piv_done  = (ptr_q == '0) || (b_c < a_c);
	assign sts.piv_found = (ptr_q != '0);
	assign sts.suc_done  = (a_c > mem_q[piv_q]);
	assign sts.rev_done  = !(lo_q < hi_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_beat.req_type;
			idx_q <= in_beat.elem_index;
			val_q <= in_beat.elem_value;
			len_q <= len_c;
		end
		if (cmd.wr_elem && 32'(idx_q) < MAX_LEN) mem_q[idx_q[IW-1:0]] <= val_q;
		if (cmd.swap) begin
			mem_q[piv_q] <= a_c;
			mem_q[ptr_q] <= mem_q[piv_q];
		end
		if (cmd.rev_step && lo_q < hi_q) begin
			mem_q[lo_q] <= mem_q[hi_q];
			mem_q[hi_q] <= mem_q[lo_q];
		end
		if (cmd.sum_clr) begin
			ptr_q <= '0;
			sum_q <= 16'(mem_q[0]);
		end else if (cmd.sum_step) begin
			ptr_q <= ptr_q + IW'(1);
			sum_q <= sum_q + 16'(mem_q[ptr_q + IW'(1)] * (16'(ptr_q) + 16'd2));
		end else if (cmd.load) begin
			ptr_q <= last_c;
		end else if (cmd.piv_step) begin
			ptr_q <= ptr_q - IW'(1);
		end else if (cmd.suc_step) begin
			ptr_q <= ptr_q - IW'(1);
		end
		if (cmd.rev_init) begin
			if (sts.piv_found) begin
				piv_q <= ptr_q - IW'(1);
				ptr_q <= last_c;
			end else begin
				piv_q <= '0;
			end
			lo_q <= ptr_q;
			hi_q <= last_c;
		end else if (cmd.rev_step) begin
			lo_q <= lo_q + IW'(1);
			hi_q <= hi_q - IW'(1);
		end
		if (cmd.finish) begin
			res.read_value <= (req_q == lps_pkg::REQ_READ && 32'(idx_q) < MAX_LEN)
				? mem_q[idx_q[IW-1:0]] : 8'd0;
			res.arrangement_sum <= sum_q;
			res.running_total <= tot_q;
			res.step_count <= cnt_q;
			res.pivot_position <= (req_q == lps_pkg::REQ_ADVANCE) ? 4'(piv_q) : 4'd0;
			res.wrapped <= (req_q == lps_pkg::REQ_ADVANCE) && !sts_w_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q <= '0;
			cnt_q <= '0;
			sts_w_q <= 1'b0;
		end else begin
			if (cmd.clr_tot) begin
				tot_q <= '0;
				cnt_q <= '0;
			end else if (cmd.acc) begin
				tot_q <= tot_q + 64'(sum_q);
				cnt_q <= cnt_q + 48'd1;
			end
			if (cmd.rev_init) sts_w_q <= sts.piv_found;
		end
	end
endmodule
`default_nettype wire

[sv/lps_ctrl.sv]
// sequencing state machine
`default_nettype none
module lps_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire [1:0]          req_type,
	output logic               out_valid,
	input  wire                out_stall,
	input  wire lps_pkg::sts_t sts,
	output lps_pkg::cmd_t      cmd
);
	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001, S_PSUM = 10'b0000000010, S_PIV = 10'b0000000100,
		S_SUC  = 10'b0000001000, S_SWAP = 10'b0000010000, S_REV = 10'b0000100000,
		S_SUM  = 10'b0001000000, S_FIN  = 10'b0010000000, S_OUT = 10'b0100000000,
		S_WR   = 10'b1000000000
	} state_t;
	state_t st_q, st_d;
	logic [1:0] rq_q;

	assign in_stall = (st_q != S_IDLE);
	assign out_valid = (st_q == S_OUT);

	always_comb begin
		st_d = st_q;
		cmd = '0;
		case (st_q)
			S_IDLE: if (in_valid) begin
				cmd.load = 1'b1;
				st_d = (req_type == lps_pkg::REQ_WRITE) ? S_WR : S_PSUM;
			end
			S_WR: begin
				cmd.wr_elem = 1'b1;
				cmd.clr_tot = 1'b1;
				st_d = S_PSUM;
			end
			S_PSUM: begin
				cmd.sum_clr = 1'b1;
				st_d = S_SUM;
			end
			S_PIV: if (sts.piv_done) begin
				cmd.rev_init = 1'b1;
				st_d = sts.piv_found ? S_SUC : S_REV;
			end else cmd.piv_step = 1'b1;
			S_SUC: if (sts.suc_done) st_d = S_SWAP;
			else cmd.suc_step = 1'b1;
			S_SWAP: begin
				cmd.swap = 1'b1;
				st_d = S_REV;
			end
			S_REV: if (sts.rev_done) begin
				cmd.sum_clr = 1'b1;
				st_d = S_FIN;
			end else cmd.rev_step = 1'b1;
			S_SUM: if (sts.sum_done) begin
				if (rq_q == lps_pkg::REQ_ADVANCE) begin
					cmd.acc = 1'b1;
					cmd.load = 1'b0;
					st_d = S_PIV;
				end else begin
					cmd.finish = 1'b1;
					st_d = S_OUT;
				end
			end else cmd.sum_step = 1'b1;
			S_FIN: if (sts.sum_done) begin
				cmd.finish = 1'b1;
				st_d = S_OUT;
			end else cmd.sum_step = 1'b1;
			S_OUT: if (!out_stall) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			rq_q <= lps_pkg::REQ_WRITE;
		end else begin
			st_q <= st_d;
			if (st_q == S_IDLE && in_valid) rq_q <= req_type;
		end
	end
endmodule
`default_nettype wire

[sv/lex_permutation_stepper.sv]
// top level: lexicographic permutation stepper
//
//  channel | direction | handshake          | payload
//  in      | into      | in_valid/in_stall  | in_beat (req_type, elem_index, elem_value)
//  out     | out of    | out_valid/out_stall| out_beat (six result fields)
//  apb     | into      | psel/penable/pready| seq_length at byte address 0
//
// one beat at a time; an advance does a sum pass, pivot scan, successor scan, swap,
// tail reversal and a second sum pass (successor scan and swap only when a pivot is found),
// a read does a sum pass, a write stores the element and then does a sum pass
// the element store is a register file stepped one position per cycle
// arst_n clears control, total and count; elements are undefined until written
// while the result beat waits under out_stall no new beat is taken
`default_nettype none
module lex_permutation_stepper #(
	parameter int MAX_LEN = lps_pkg::MaxLenDefault
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire lps_pkg::in_beat_t in_beat,
	output logic                   out_valid,
	input  wire                    out_stall,
	output lps_pkg::out_beat_t     out_beat,
	input  wire                    psel,
	input  wire                    penable,
	input  wire                    pwrite,
	input  wire [1:0]              paddr,
	input  wire [31:0]             pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	lps_pkg::cmd_t cmd;
	lps_pkg::sts_t sts;
	logic [4:0] len_q;

	// length register, only address zero holds anything
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) len_q <= 5'd16;
		else if (psel && penable && pwrite && paddr == 2'd0) len_q <= pwdata[4:0];
	end
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {27'd0, len_q} : 32'd0;

	lps_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .req_type(in_beat.req_type),
		.out_valid, .out_stall, .sts, .cmd
	);

	lps_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
		.clk, .arst_n, .cmd, .sts, .in_beat, .seq_length(len_q), .res(out_beat)
	);
endmodule
`default_nettype wire
